// ----- rtl/rlfs_pkg.sv -----
// rlfs_pkg: shared constants, command codes and helpers for the led matrix frame scanner
// no dependencies; used by the interfaces and the top level
package rlfs_pkg;

  // panel geometry
  localparam int ROW_PAIRS  = 16;
  localparam int ROW_W      = $clog2(ROW_PAIRS);
  localparam int FRAME_ROWS = 32;
  localparam int FROW_W     = $clog2(FRAME_ROWS);
  localparam int COLOURS    = 3;
  localparam int WORDS      = COLOURS * FRAME_ROWS;
  localparam int ADDR_W     = $clog2(WORDS);
  localparam int WORD_W     = 64;
  localparam int X_W        = $clog2(WORD_W);

  // field widths
  localparam int CMD_W  = 2;
  localparam int COL_W  = 2;
  localparam int SEL_W  = 4;
  localparam int DUTY_W = 10;

  // scan sequence
  localparam int SCAN_WORDS = 6;
  localparam int SCAN_CNT_W = $clog2(SCAN_WORDS);
  localparam logic [SCAN_CNT_W-1:0] SCAN_LAST = SCAN_CNT_W'(SCAN_WORDS - 1);

  localparam logic [DUTY_W-1:0] DUTY_MAX        = 10'd1023;
  localparam logic [DUTY_W-1:0] BRIGHTNESS_INIT = 10'd511;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

  // colour planes
  localparam logic [COL_W-1:0] COLOUR_TOP  = 2'd2;
  localparam logic [COL_W-1:0] COLOUR_NONE = 2'd3;

  // word address of a row and colour plane: 3*row + colour
  function automatic logic [ADDR_W-1:0] word_addr(input logic [FROW_W-1:0] row,
                                                  input logic [COL_W-1:0] colour);
    word_addr = (ADDR_W'(row) << 1) + ADDR_W'(row) + ADDR_W'(colour);
  endfunction

endpackage

// ----- rtl/rlfs_if.sv -----
// rlfs channel interfaces: command input, shift word output, brightness write
// depends on rlfs_pkg for field widths
interface rlfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [rlfs_pkg::CMD_W-1:0]    command;
  logic [rlfs_pkg::X_W-1:0]      pixel_x;
  logic [rlfs_pkg::FROW_W-1:0]   pixel_y;
  logic [rlfs_pkg::COL_W-1:0]    color;
  logic                          pixel_value;

  modport source (output valid, command, pixel_x, pixel_y, color, pixel_value, input ready);
  modport sink   (input valid, command, pixel_x, pixel_y, color, pixel_value, output ready);
endinterface

interface rlfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [rlfs_pkg::WORD_W-1:0]   shift_word;
  logic [rlfs_pkg::SEL_W-1:0]    row_select;
  logic [rlfs_pkg::DUTY_W-1:0]   off_duty;
  logic                          last_word;

  modport source (output valid, shift_word, row_select, off_duty, last_word, input ready);
  modport sink   (input valid, shift_word, row_select, off_duty, last_word, output ready);
endinterface

interface rlfs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rlfs_pkg::DUTY_W-1:0]   brightness;

  modport source (output valid, brightness, input ready);
  modport sink   (input valid, brightness, output ready);
endinterface

// ----- rtl/rlfs_ram.sv -----
// rlfs_ram: generic single write port, single read port ram with registered read
// no dependencies; read data holds while no read is issued
module rlfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rgb_led_matrix_frame_scan.sv -----
// rgb_led_matrix_frame_scan: 64x32 rgb frame store with row-pair scan output
// depends on rlfs_pkg, the rlfs channel interfaces and rlfs_ram
// scan: six words; the first passes the ram read register and the output
//   register, then one per cycle unless stalled, set by the single ram read port
// pixel write: read, modify, write back; clear and unused codes stay in idle
// reset: rows restart at zero, brightness 511; the frame reads as zero through
//   per-word valid flops, so no clearing pass follows reset
module rgb_led_matrix_frame_scan (
  input  logic            clk,
  input  logic            rst,
  rlfs_in_if.sink         req,
  rlfs_out_if.source      rsp,
  rlfs_cfg_if.sink        cfg
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WRITE = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t state;

  logic [rlfs_pkg::ROW_W-1:0]      scan_row;
  logic [rlfs_pkg::DUTY_W-1:0]     brightness;
  logic [rlfs_pkg::SCAN_CNT_W-1:0] word_cnt;
  logic [rlfs_pkg::WORDS-1:0]      valid_bits;

  // latched pixel write
  logic [rlfs_pkg::ADDR_W-1:0]     wr_addr;
  logic [rlfs_pkg::X_W-1:0]        wr_x;
  logic                            wr_value;

  // ram read stage
  logic                            pending;
  logic                            pend_last;
  logic                            pend_vbit;
  logic [rlfs_pkg::SEL_W-1:0]      pend_row;

  // output register
  logic                            out_valid;
  logic [rlfs_pkg::WORD_W-1:0]     shift_word;
  logic [rlfs_pkg::SEL_W-1:0]      row_select;
  logic [rlfs_pkg::DUTY_W-1:0]     off_duty;
  logic                            last_word;

  // ram ports
  logic                            ram_we;
  logic [rlfs_pkg::WORD_W-1:0]     ram_wdata;
  logic                            rd_en;
  logic                            rd_scan;
  logic [rlfs_pkg::ADDR_W-1:0]     rd_addr;
  logic [rlfs_pkg::WORD_W-1:0]     rd_data;

  logic                            accept;
  logic                            load;
  logic                            scan_issue;
  logic [rlfs_pkg::SCAN_CNT_W-1:0] scan_k;
  logic [rlfs_pkg::FROW_W-1:0]     row_lo;
  logic [rlfs_pkg::FROW_W-1:0]     row_hi;
  logic [rlfs_pkg::COL_W-1:0]      k_colour;
  logic [rlfs_pkg::FROW_W-1:0]     k_row;
  logic [rlfs_pkg::WORD_W-1:0]     base_word;
  logic [rlfs_pkg::WORD_W-1:0]     bit_mask;

  // handshakes
  assign load      = pending & (~out_valid | rsp.ready);
  assign req.ready = (state == ST_IDLE) & (~pending | load);
  assign accept    = req.valid & req.ready;
  assign cfg.ready = 1'b1;

  // row pair addresses
  assign row_lo   = rlfs_pkg::FROW_W'(scan_row);
  assign row_hi   = row_lo + rlfs_pkg::FROW_W'(rlfs_pkg::ROW_PAIRS);
  assign k_colour = rlfs_pkg::COLOUR_TOP - rlfs_pkg::COL_W'(scan_k[rlfs_pkg::SCAN_CNT_W-1:1]);
  assign k_row    = scan_k[0] ? row_lo : row_hi;

  // read issue: scan words, or the read half of a pixel write
  always_comb begin
    scan_issue = 1'b0;
    scan_k     = word_cnt;
    rd_en      = 1'b0;
    rd_scan    = 1'b0;
    rd_addr    = rlfs_pkg::word_addr(req.pixel_y, req.color);
    case (state)
      ST_IDLE: begin
        if (accept && req.command == rlfs_pkg::CMD_SCAN) begin
          scan_issue = 1'b1;
          scan_k     = '0;
        end else if (accept && req.command == rlfs_pkg::CMD_WRITE &&
                     req.color != rlfs_pkg::COLOUR_NONE) begin
          rd_en = 1'b1;
        end
      end
      ST_SCAN: begin
        scan_issue = ~pending | load;
      end
      default: begin
        scan_issue = 1'b0;
      end
    endcase
    if (scan_issue) begin
      rd_en   = 1'b1;
      rd_scan = 1'b1;
      rd_addr = rlfs_pkg::word_addr(k_row, k_colour);
    end
  end

  // modify half of a pixel write
  assign base_word = pend_vbit ? rd_data : '0;
  assign bit_mask  = rlfs_pkg::WORD_W'(1) << (rlfs_pkg::X_W'(rlfs_pkg::WORD_W - 1) - wr_x);
  assign ram_wdata = wr_value ? (base_word | bit_mask) : (base_word & ~bit_mask);
  assign ram_we    = (state == ST_WRITE);

  rlfs_ram #(
    .WIDTH (rlfs_pkg::WORD_W),
    .DEPTH (rlfs_pkg::WORDS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // sequencer, row counter and frame valid flops
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_row   <= '0;
      word_cnt   <= '0;
      valid_bits <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.command)
              rlfs_pkg::CMD_WRITE: begin
                if (req.color != rlfs_pkg::COLOUR_NONE) begin
                  state <= ST_WRITE;
                end
              end
              rlfs_pkg::CMD_CLEAR: begin
                valid_bits <= '0;
              end
              rlfs_pkg::CMD_SCAN: begin
                state    <= ST_SCAN;
                word_cnt <= rlfs_pkg::SCAN_CNT_W'(1);
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WRITE: begin
          valid_bits[wr_addr] <= 1'b1;
          state               <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_issue) begin
            word_cnt <= word_cnt + 1'b1;
            if (word_cnt == rlfs_pkg::SCAN_LAST) begin
              state    <= ST_IDLE;
              scan_row <= (scan_row == rlfs_pkg::ROW_W'(rlfs_pkg::ROW_PAIRS - 1)) ?
                          '0 : scan_row + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // latch the pixel write fields
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr  <= rlfs_pkg::word_addr(req.pixel_y, req.color);
      wr_x     <= req.pixel_x;
      wr_value <= req.pixel_value;
    end
  end

  // read stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (rd_en && rd_scan) begin
      pending <= 1'b1;
    end else if (load) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_vbit <= valid_bits[rd_addr];
      pend_last <= (scan_k == rlfs_pkg::SCAN_LAST);
      pend_row  <= row_lo[rlfs_pkg::SEL_W-1:0];
    end
  end

  // brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= rlfs_pkg::BRIGHTNESS_INIT;
    end else if (cfg.valid && cfg.ready) begin
      brightness <= cfg.brightness;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_word <= pend_vbit ? rd_data : '0;
      row_select <= pend_row;
      off_duty   <= rlfs_pkg::DUTY_MAX - brightness;
      last_word  <= pend_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.shift_word = shift_word;
  assign rsp.row_select = row_select;
  assign rsp.off_duty   = off_duty;
  assign rsp.last_word  = last_word;

endmodule
